[rtl/core/psp_pkg.sv]
`default_nettype none

package psp_pkg;

  // Fixed-point format of coordinates and registers
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 32;
  localparam int SC_W      = 18;

  // Exact widths of the intermediate terms
  localparam int DIFF_W  = 33;
  localparam int MSE_W   = SC_W + 32;
  localparam int MD_W    = SC_W + DIFF_W;
  localparam int NR_W    = MSE_W + 1;
  localparam int PP_W    = 64;
  localparam int NUM_W   = PP_W + 1;
  localparam int DEN_W   = MD_W + 1;
  localparam int QUO_W   = 32;
  localparam int TOP_W   = NUM_W + FRAC_BITS - QUO_W;
  localparam int CMP_W   = (TOP_W > DEN_W) ? TOP_W : DEN_W;
  localparam int DIV_LAT = QUO_W + 1;
  localparam int SAT_W   = PP_W + 2;

  localparam logic signed [31:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_VIEW_SINE       = 3'd0,
    REG_VIEW_COSINE     = 3'd1,
    REG_EYE_Y           = 3'd2,
    REG_EYE_Z           = 3'd3,
    REG_SCREEN_H_ORIGIN = 3'd4,
    REG_SCREEN_H_SCALE  = 3'd5,
    REG_SCREEN_V_ORIGIN = 3'd6,
    REG_SCREEN_V_SCALE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SC_W-1:0] view_sine;
    logic signed [SC_W-1:0] view_cosine;
    logic signed [31:0]     eye_y;
    logic signed [31:0]     eye_z;
    logic signed [31:0]     h_origin;
    logic signed [31:0]     h_scale;
    logic signed [31:0]     v_origin;
    logic signed [31:0]     v_scale;
  } cfg_t;

  // Item fields that ride alongside the dividers
  typedef struct packed {
    logic               valid;
    logic               degen;
    logic               neg_r;
    logic               neg_z;
    logic signed [31:0] x;
    logic signed [31:0] z;
  } side_t;

  // Front end result: sidecar plus divider operands
  typedef struct packed {
    side_t            side;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] num_z;
  } front_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_W'(S32_MAX)) r = S32_MAX;
    else if (v < SAT_W'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Apply sign to a quotient magnitude and clamp to 32 bits
  function automatic logic signed [31:0] quo_sat(input logic neg, input logic ovf,
                                                 input logic [QUO_W-1:0] q);
    logic signed [31:0] r;
    if (ovf) r = neg ? S32_MIN : S32_MAX;
    else if (!neg) r = q[QUO_W-1] ? S32_MAX : signed'(q);
    else if (q > 32'h8000_0000) r = S32_MIN;
    else r = -signed'(q);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/psp_div.sv]
`default_nettype none

module psp_div
  import psp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o,
  output logic                  ovf_o
);

  logic [DEN_W-1:0] rem_q [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic [QUO_W-1:0] low_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic             ovf_q [DIV_LAT];

  logic [NUM_W+FRAC_BITS-1:0] nsh;
  logic [CMP_W-1:0]           top_c;

  // Scale the dividend and split off the part above the quotient bits
  assign nsh   = {num_i, {FRAC_BITS{1'b0}}};
  assign top_c = CMP_W'(nsh[NUM_W+FRAC_BITS-1:QUO_W]);

  // Flag a quotient of 2^32 or more, seed the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(top_c);
      quo_q[0] <= '0;
      low_q[0] <= nsh[QUO_W-1:0];
      den_q[0] <= den_i;
      ovf_q[0] <= (top_c >= CMP_W'(den_i));
    end
  end

  // One restoring step per stage
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [DEN_W:0] r2;
    logic           take;
    assign r2   = {rem_q[k-1], low_q[k-1][QUO_W-1]};
    assign take = (r2 >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DEN_W'(r2 - {1'b0, den_q[k-1]}) : DEN_W'(r2);
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], take};
        low_q[k] <= {low_q[k-1][QUO_W-2:0], 1'b0};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

`default_nettype wire

[rtl/core/psp_front.sv]
`default_nettype none

module psp_front
  import psp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  input  wire cfg_t               cfg_i,
  output front_t                  front_o
);

  // Stage 1 registers
  logic                     v1_q;
  logic signed [31:0]       x1_q, z1_q;
  logic signed [DIFF_W-1:0] dy1_q, dz1_q;
  logic signed [PP_W-1:0]   ezy1_q, eyz1_q;
  logic signed [MSE_W-1:0]  sey1_q, cez1_q;
  // Stage 2 registers
  logic                     v2_q;
  logic signed [31:0]       x2_q, z2_q;
  logic signed [MD_W-1:0]   md1_q, md2_q;
  logic signed [NR_W-1:0]   nr2_q;
  logic signed [NUM_W-1:0]  nz2_q;
  // Stage 3 registers
  logic                     v3_q;
  logic signed [31:0]       x3_q, z3_q;
  logic signed [DEN_W-1:0]  d3_q;
  logic signed [NR_W-1:0]   nr3_q;
  logic signed [NUM_W-1:0]  nz3_q;
  // Stage 4 registers
  front_t                   f4_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Form differences and the eye products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x_i;
      z1_q   <= z_i;
      dy1_q  <= DIFF_W'(cfg_i.eye_y) - DIFF_W'(y_i);
      dz1_q  <= DIFF_W'(cfg_i.eye_z) - DIFF_W'(z_i);
      ezy1_q <= cfg_i.eye_z * y_i;
      eyz1_q <= cfg_i.eye_y * z_i;
      sey1_q <= cfg_i.view_sine * cfg_i.eye_y;
      cez1_q <= cfg_i.view_cosine * cfg_i.eye_z;
    end
  end

  // Weight differences by sine and cosine, build numerators
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q  <= x1_q;
      z2_q  <= z1_q;
      md1_q <= cfg_i.view_sine * dy1_q;
      md2_q <= cfg_i.view_cosine * dz1_q;
      nr2_q <= NR_W'(sey1_q) + NR_W'(cez1_q);
      nz2_q <= NUM_W'(ezy1_q) - NUM_W'(eyz1_q);
    end
  end

  // Sum the denominator
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q  <= x2_q;
      z3_q  <= z2_q;
      d3_q  <= DEN_W'(md1_q) + DEN_W'(md2_q);
      nr3_q <= nr2_q;
      nz3_q <= nz2_q;
    end
  end

  // Split into signs and magnitudes for the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_q <= '0;
    end else if (en_i) begin
      f4_q.side.valid <= v3_q;
      f4_q.side.degen <= (d3_q == '0);
      f4_q.side.neg_r <= nr3_q[NR_W-1] ^ d3_q[DEN_W-1];
      f4_q.side.neg_z <= nz3_q[NUM_W-1] ^ d3_q[DEN_W-1];
      f4_q.side.x     <= x3_q;
      f4_q.side.z     <= z3_q;
      f4_q.den        <= d3_q[DEN_W-1] ? DEN_W'(-d3_q) : DEN_W'(d3_q);
      f4_q.num_r      <= nr3_q[NR_W-1] ? NUM_W'(-NUM_W'(nr3_q)) : NUM_W'(nr3_q);
      f4_q.num_z      <= nz3_q[NUM_W-1] ? NUM_W'(-nz3_q) : NUM_W'(nz3_q);
    end
  end

  assign front_o = f4_q;

endmodule

`default_nettype wire

[rtl/core/psp_back.sv]
`default_nettype none

module psp_back
  import psp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire side_t              side_i,
  input  wire logic [QUO_W-1:0]   quo_r_i,
  input  wire logic               ovf_r_i,
  input  wire logic [QUO_W-1:0]   quo_z_i,
  input  wire logic               ovf_z_i,
  input  wire cfg_t               cfg_i,
  output logic                    valid_o,
  output logic signed [31:0]      depth_o,
  output logic signed [31:0]      h_o,
  output logic signed [31:0]      v_o,
  output logic                    degen_o
);

  logic                   v5_q, v6_q, v7_q, v8_q, v9_q;
  logic                   dg5_q, dg6_q, dg7_q, dg8_q, dg9_q;
  logic signed [31:0]     x5_q, z5_q, z6_q, z7_q, z8_q, z9_q;
  logic signed [31:0]     zr5_q, zz5_q;
  logic signed [PP_W-1:0] pyy6_q, pv6_q, ph8_q;
  logic signed [31:0]     yy7_q, sv7_q, sv8_q, h9_q, sv9_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= side_i.valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Sign and clamp the quotients
      dg5_q  <= side_i.degen;
      x5_q   <= side_i.x;
      z5_q   <= side_i.z;
      zr5_q  <= quo_sat(side_i.neg_r, ovf_r_i, quo_r_i);
      zz5_q  <= quo_sat(side_i.neg_z, ovf_z_i, quo_z_i);
      // Horizontal value and vertical scaling products
      dg6_q  <= dg5_q;
      z6_q   <= z5_q;
      pyy6_q <= zr5_q * x5_q;
      pv6_q  <= zz5_q * cfg_i.v_scale;
      // Rescale, clamp, add vertical origin
      dg7_q  <= dg6_q;
      z7_q   <= z6_q;
      yy7_q  <= sat32(SAT_W'(pyy6_q >>> FRAC_BITS));
      sv7_q  <= sat32(SAT_W'(cfg_i.v_origin) + SAT_W'(pv6_q >>> FRAC_BITS));
      // Horizontal scaling product
      dg8_q  <= dg7_q;
      z8_q   <= z7_q;
      sv8_q  <= sv7_q;
      ph8_q  <= yy7_q * cfg_i.h_scale;
      // Add horizontal origin; fall back to origins on a zero denominator
      dg9_q  <= dg8_q;
      z9_q   <= z8_q;
      h9_q   <= dg8_q ? cfg_i.h_origin
                      : sat32(SAT_W'(cfg_i.h_origin) + SAT_W'(ph8_q >>> FRAC_BITS));
      sv9_q  <= dg8_q ? cfg_i.v_origin : sv8_q;
    end
  end

  assign valid_o = v9_q;
  assign depth_o = z9_q;
  assign h_o     = h9_q;
  assign v_o     = sv9_q;
  assign degen_o = dg9_q;

endmodule

`default_nettype wire

[rtl/core/perspective_screen_projection_core.sv]
// Perspective screen projection core.
// Input channel: in_valid_i / in_ready_o with pt_x_i, pt_y_i, pt_z_i, one
// view-relative point per item, signed Q16.16.
// Output channel: out_valid_o / out_ready_i with depth_out_o, screen_h_o,
// screen_v_o and degenerate_o, one result per point, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i
// (0 view sine, 1 view cosine, 2 eye y, 3 eye z, 4..7 screen origins and
// scales). Write only while no item is in flight.
// Pipeline: an accepted item passes through four front stages, a 33-stage
// divider pair (an overflow check, then one quotient bit per stage) and
// five back stages. One item per cycle while the output is not stalled.
// A zero denominator returns the screen origins with degenerate_o set.
// Reset empties the pipeline and loads the register defaults (cosine and
// scales 1.0, the rest 0).
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// in the same cycle; nothing is lost or repeated.
`default_nettype none

module perspective_screen_projection_core
  import psp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] pt_x_i,
  input  wire logic signed [31:0] pt_y_i,
  input  wire logic signed [31:0] pt_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      depth_out_o,
  output logic signed [31:0]      screen_h_o,
  output logic signed [31:0]      screen_v_o,
  output logic                    degenerate_o
);

  cfg_t             cfg_q;
  logic             en;
  front_t           front;
  side_t            side_q [DIV_LAT];
  logic [QUO_W-1:0] quo_r, quo_z;
  logic             ovf_r, ovf_z;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_sine   <= '0;
      cfg_q.view_cosine <= SC_W'(FX_ONE);
      cfg_q.eye_y       <= '0;
      cfg_q.eye_z       <= '0;
      cfg_q.h_origin    <= '0;
      cfg_q.h_scale     <= FX_ONE;
      cfg_q.v_origin    <= '0;
      cfg_q.v_scale     <= FX_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        REG_VIEW_SINE:       cfg_q.view_sine   <= cfg_data_i[SC_W-1:0];
        REG_VIEW_COSINE:     cfg_q.view_cosine <= cfg_data_i[SC_W-1:0];
        REG_EYE_Y:           cfg_q.eye_y       <= cfg_data_i;
        REG_EYE_Z:           cfg_q.eye_z       <= cfg_data_i;
        REG_SCREEN_H_ORIGIN: cfg_q.h_origin    <= cfg_data_i;
        REG_SCREEN_H_SCALE:  cfg_q.h_scale     <= cfg_data_i;
        REG_SCREEN_V_ORIGIN: cfg_q.v_origin    <= cfg_data_i;
        REG_SCREEN_V_SCALE:  cfg_q.v_scale     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold every stage while a result waits at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  psp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (pt_x_i),
    .y_i     (pt_y_i),
    .z_i     (pt_z_i),
    .cfg_i   (cfg_q),
    .front_o (front)
  );

  psp_div u_div_r (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.num_r),
    .den_i (front.den),
    .quo_o (quo_r),
    .ovf_o (ovf_r)
  );

  psp_div u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.num_z),
    .den_i (front.den),
    .quo_o (quo_z),
    .ovf_o (ovf_z)
  );

  // Carry item fields alongside the dividers
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en) begin
        if (k == 0) begin
          side_q[k] <= front.side;
        end else begin
          side_q[k] <= side_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  psp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .side_i  (side_q[DIV_LAT-1]),
    .quo_r_i (quo_r),
    .ovf_r_i (ovf_r),
    .quo_z_i (quo_z),
    .ovf_z_i (ovf_z),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .depth_o (depth_out_o),
    .h_o     (screen_h_o),
    .v_o     (screen_v_o),
    .degen_o (degenerate_o)
  );

endmodule

`default_nettype wire

[rtl/core/psp_checker.sv]
`default_nettype none

module psp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] depth_out_o,
  input wire logic [31:0] screen_h_o,
  input wire logic [31:0] screen_v_o,
  input wire logic        degenerate_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(depth_out_o)
      && $stable(screen_h_o) && $stable(screen_v_o) && $stable(degenerate_o))
    else $error("stalled result changed");

  // Input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow output stall");

  // Nothing leaves right after reset
  a_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind perspective_screen_projection_core psp_checker u_psp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .depth_out_o  (depth_out_o),
  .screen_h_o   (screen_h_o),
  .screen_v_o   (screen_v_o),
  .degenerate_o (degenerate_o)
);

`default_nettype wire
